### rtl/sle_pkg.sv
// sle_pkg: operation codes, status codes and shared types for the list engine.
// Used by sle_cell and sequential_list_engine_top; no dependencies.
`timescale 1ns / 1ps
`default_nettype none

package sle_pkg;

   typedef enum logic [3:0] {
      FN_INSERT     = 4'd0,
      FN_REMOVE     = 4'd1,
      FN_READ       = 4'd2,
      FN_FIND_NAME  = 4'd3,
      FN_FIND_VALUE = 4'd4,
      FN_FIND_BOTH  = 4'd5,
      FN_REVERSE    = 4'd6,
      FN_CLEAR      = 4'd7,
      FN_PUSH       = 4'd8,
      FN_POP        = 4'd9
   } func_type;

   typedef enum logic [1:0] {
      ST_OK       = 2'd0,
      ST_BADPOS   = 2'd1,
      ST_FULL     = 2'd2,
      ST_NOTFOUND = 2'd3
   } status_type;

   // what every cell does in the cycle of an accepted beat
   typedef enum logic [1:0] {
      CELL_HOLD   = 2'd0,
      CELL_INSERT = 2'd1,
      CELL_REMOVE = 2'd2
   } cell_op_type;

   // broadcast to all cells: data to load and the search key
   typedef struct packed {
      logic [31:0]        name;
      logic signed [31:0] value;
      logic               use_name;
      logic               use_value;
   } key_type;

endpackage

`default_nettype wire

### rtl/sequential_list_engine_top.sv
// A result beat is registered and is on rsp_tdata in the cycle after its request beat is taken.
// Throughput: one operation per cycle unless stalled; every operation, reverse included,
// completes in the cycle it is taken (reverse flips an orientation bit instead of moving entries).
// req_tready stays high while the output register is empty or being drained.
// Reset clears the entry count, the orientation bit and the output valid; entry data is not
// cleared and is undefined until written.
`timescale 1ns / 1ps
`default_nettype none

module sequential_list_engine_top #(
   parameter int unsigned DEPTH = 16
) (
   input  wire         clock,
   input  wire         reset,
   input  wire         req_tvalid,
   output logic        req_tready,
   // [3:0] func, [8:4] position, [40:9] name_tag, [72:41] item_value, [79:73] zero
   input  wire  [79:0] req_tdata,
   output logic        rsp_tvalid,
   input  wire         rsp_tready,
   // [1:0] status, [6:2] found_position, [38:7] out_name_tag, [70:39] out_value,
   // [75:71] list_length, [79:76] zero
   output logic [79:0] rsp_tdata
);

   localparam int unsigned IW   = (DEPTH > 1) ? $clog2(DEPTH) : 1;
   localparam int unsigned CW   = $clog2(DEPTH + 1);
   localparam int unsigned CMPW = ((CW > 5) ? CW : 5) + 1;

   // request fields
   sle_pkg::func_type  func;
   logic [4:0]         position;
   logic [31:0]        name_tag;
   logic signed [31:0] item_value;

   assign func       = sle_pkg::func_type'(req_tdata[3:0]);
   assign position   = req_tdata[8:4];
   assign name_tag   = req_tdata[40:9];
   assign item_value = req_tdata[72:41];

   logic                 accept;
   logic [CW-1:0]        count_ff;
   logic [CW-1:0]        count_in;
   logic                 orient_ff;   // set: logical order is physical order reversed
   logic                 orient_in;

   sle_pkg::cell_op_type cell_op;
   logic [IW-1:0]        k;
   sle_pkg::key_type     key;

   logic [31:0]          cell_name  [DEPTH];
   logic signed [31:0]   cell_value [DEPTH];
   logic [DEPTH-1:0]     cell_match;

   logic                 rsp_valid_ff;
   sle_pkg::status_type  status_ff,  status_in;
   logic [4:0]           fpos_ff,    fpos_in;
   logic [31:0]          oname_ff,   oname_in;
   logic signed [31:0]   ovalue_ff,  ovalue_in;
   logic [4:0]           length_ff;

   assign req_tready = !rsp_valid_ff || rsp_tready;
   assign accept     = req_tvalid && req_tready;

   assign key.name      = name_tag;
   assign key.value     = item_value;
   assign key.use_name  = (func == sle_pkg::FN_FIND_NAME)  || (func == sle_pkg::FN_FIND_BOTH);
   assign key.use_value = (func == sle_pkg::FN_FIND_VALUE) || (func == sle_pkg::FN_FIND_BOTH);

   // ---- cell row ----
   for (genvar i = 0; i < DEPTH; i++) begin : g_cell
      logic [31:0]        lname, rname;
      logic signed [31:0] lvalue, rvalue;
      if (i == 0) begin : g_first
         assign lname  = name_tag;
         assign lvalue = item_value;
      end else begin : g_mid_l
         assign lname  = cell_name[i-1];
         assign lvalue = cell_value[i-1];
      end
      if (i == DEPTH - 1) begin : g_last
         assign rname  = '0;
         assign rvalue = '0;
      end else begin : g_mid_r
         assign rname  = cell_name[i+1];
         assign rvalue = cell_value[i+1];
      end
      sle_cell #(
         .IW  (IW),
         .CW  (CW),
         .IDX (i)
      ) u_cell (
         .clock       (clock),
         .op          (cell_op),
         .k           (k),
         .count       (count_ff),
         .key         (key),
         .left_name   (lname),
         .left_value  (lvalue),
         .right_name  (rname),
         .right_value (rvalue),
         .name_out    (cell_name[i]),
         .value_out   (cell_value[i]),
         .match       (cell_match[i])
      );
   end

   // first logical match: lowest physical hit, or highest when reversed
   logic          hit;
   logic [IW-1:0] hit_idx;

   always_comb begin
      hit     = 1'b0;
      hit_idx = '0;
      for (int j = 0; j < DEPTH; j++) begin
         if (cell_match[j] && (orient_ff || !hit)) begin
            hit     = 1'b1;
            hit_idx = IW'(j);
         end
      end
   end

   // ---- decode ----
   logic [CMPW-1:0] pos_e, cnt_e, hit_e, fpos_e;
   logic            ins_ok, rd_ok, full;
   logic [IW-1:0]   ins_k, rm_k, end_ins_k, end_rm_k;

   assign pos_e     = CMPW'(position);
   assign cnt_e     = CMPW'(count_ff);
   assign hit_e     = CMPW'(hit_idx);
   assign ins_ok    = (pos_e != '0) && (pos_e <= cnt_e + CMPW'(1));
   assign rd_ok     = (pos_e != '0) && (pos_e <= cnt_e);
   assign full      = (count_ff == CW'(DEPTH));
   assign ins_k     = orient_ff ? IW'(cnt_e + CMPW'(1) - pos_e) : IW'(pos_e - CMPW'(1));
   assign rm_k      = orient_ff ? IW'(cnt_e - pos_e) : IW'(pos_e - CMPW'(1));
   assign end_ins_k = orient_ff ? '0 : IW'(count_ff);
   assign end_rm_k  = orient_ff ? '0 : IW'(count_ff - CW'(1));
   assign fpos_e    = orient_ff ? (cnt_e - hit_e) : (hit_e + CMPW'(1));

   always_comb begin
      cell_op   = sle_pkg::CELL_HOLD;
      k         = rm_k;
      count_in  = count_ff;
      orient_in = orient_ff;
      status_in = sle_pkg::ST_OK;
      fpos_in   = '0;
      oname_in  = '0;
      ovalue_in = '0;
      case (func)
         sle_pkg::FN_INSERT: begin
            k = ins_k;
            if (!ins_ok) begin
               status_in = sle_pkg::ST_BADPOS;
            end else if (full) begin
               status_in = sle_pkg::ST_FULL;
            end else begin
               cell_op  = sle_pkg::CELL_INSERT;
               count_in = count_ff + CW'(1);
            end
         end
         sle_pkg::FN_PUSH: begin
            k = end_ins_k;
            if (full) begin
               status_in = sle_pkg::ST_FULL;
            end else begin
               cell_op  = sle_pkg::CELL_INSERT;
               count_in = count_ff + CW'(1);
            end
         end
         sle_pkg::FN_REMOVE, sle_pkg::FN_READ: begin
            k = rm_k;
            if (!rd_ok) begin
               status_in = sle_pkg::ST_BADPOS;
            end else begin
               oname_in  = cell_name[rm_k];
               ovalue_in = cell_value[rm_k];
               if (func == sle_pkg::FN_REMOVE) begin
                  cell_op  = sle_pkg::CELL_REMOVE;
                  count_in = count_ff - CW'(1);
               end
            end
         end
         sle_pkg::FN_POP: begin
            k = end_rm_k;
            if (count_ff == '0) begin
               status_in = sle_pkg::ST_BADPOS;
            end else begin
               oname_in  = cell_name[end_rm_k];
               ovalue_in = cell_value[end_rm_k];
               cell_op   = sle_pkg::CELL_REMOVE;
               count_in  = count_ff - CW'(1);
            end
         end
         sle_pkg::FN_FIND_NAME, sle_pkg::FN_FIND_VALUE, sle_pkg::FN_FIND_BOTH: begin
            if (hit) begin
               fpos_in = fpos_e[4:0];
            end else begin
               status_in = sle_pkg::ST_NOTFOUND;
            end
         end
         sle_pkg::FN_REVERSE: begin
            orient_in = !orient_ff;
         end
         sle_pkg::FN_CLEAR: begin
            count_in  = '0;
            orient_in = 1'b0;
         end
         default: begin
         end
      endcase
      if (!accept) begin
         cell_op   = sle_pkg::CELL_HOLD;
         count_in  = count_ff;
         orient_in = orient_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         count_ff     <= '0;
         orient_ff    <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         count_ff  <= count_in;
         orient_ff <= orient_in;
         if (accept) begin
            rsp_valid_ff <= 1'b1;
         end else if (rsp_tready) begin
            rsp_valid_ff <= 1'b0;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (accept) begin
         status_ff <= status_in;
         fpos_ff   <= fpos_in;
         oname_ff  <= oname_in;
         ovalue_ff <= ovalue_in;
         length_ff <= 5'(CMPW'(count_in));
      end
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = {4'b0, length_ff, ovalue_ff, oname_ff, fpos_ff, status_ff};

   // ---- checks ----
   a_count_bound: assert property (@(posedge clock) disable iff (reset)
      count_ff <= CW'(DEPTH))
      else $error("entry count above depth");

   a_insert_grows: assert property (@(posedge clock) disable iff (reset)
      accept && (cell_op == sle_pkg::CELL_INSERT) |=> count_ff == $past(count_ff) + CW'(1))
      else $error("insert did not grow the list");

   a_remove_shrinks: assert property (@(posedge clock) disable iff (reset)
      accept && (cell_op == sle_pkg::CELL_REMOVE) |=> count_ff == $past(count_ff) - CW'(1))
      else $error("remove did not shrink the list");

   a_notfound_zero: assert property (@(posedge clock) disable iff (reset)
      rsp_valid_ff && (status_ff == sle_pkg::ST_NOTFOUND) |-> fpos_ff == 5'd0)
      else $error("miss reported with a position");

   a_hold_idle: assert property (@(posedge clock) disable iff (reset)
      !accept |=> (count_ff == $past(count_ff)) && (orient_ff == $past(orient_ff)))
      else $error("list state changed without a request beat");

endmodule

`default_nettype wire

### rtl/sle_cell.sv
// sle_cell: one list entry (name tag and value) with its shift and compare logic.
// Depends on sle_pkg; neighbors are wired up in sequential_list_engine_top.
`timescale 1ns / 1ps
`default_nettype none

module sle_cell #(
   parameter int unsigned IW  = 4,
   parameter int unsigned CW  = 5,
   parameter int unsigned IDX = 0
) (
   input  wire                       clock,
   input  sle_pkg::cell_op_type      op,
   input  wire  [IW-1:0]             k,
   input  wire  [CW-1:0]             count,
   input  sle_pkg::key_type          key,
   input  wire  [31:0]               left_name,
   input  wire  signed [31:0]        left_value,
   input  wire  [31:0]               right_name,
   input  wire  signed [31:0]        right_value,
   output logic [31:0]               name_out,
   output logic signed [31:0]        value_out,
   output logic                      match
);

   localparam logic [IW-1:0] MyIdx = IW'(IDX);
   localparam logic [CW-1:0] MyPos = CW'(IDX);

   logic [31:0]        name_ff;
   logic [31:0]        name_in;
   logic signed [31:0] value_ff;
   logic signed [31:0] value_in;

   always_comb begin
      name_in  = name_ff;
      value_in = value_ff;
      case (op)
         sle_pkg::CELL_INSERT: begin
            if (MyIdx == k) begin
               name_in  = key.name;
               value_in = key.value;
            end else if (MyIdx > k) begin
               name_in  = left_name;
               value_in = left_value;
            end
         end
         sle_pkg::CELL_REMOVE: begin
            if (MyIdx >= k) begin
               name_in  = right_name;
               value_in = right_value;
            end
         end
         default: begin
         end
      endcase
   end

   always_ff @(posedge clock) begin
      name_ff  <= name_in;
      value_ff <= value_in;
   end

   assign name_out  = name_ff;
   assign value_out = value_ff;
   assign match     = (MyPos < count)
                    && (!key.use_name  || (name_ff  == key.name))
                    && (!key.use_value || (value_ff == key.value));

endmodule

`default_nettype wire
